[rtl/rptq_pkg.sv]
`timescale 1ns / 1ps

package rptq_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int DRAIN_MAX = 16;

   localparam logic [QW:0]   QUEUE_DEPTH_C = (QW + 1)'(QUEUE_DEPTH);
   localparam logic [QW-1:0] QUEUE_LAST_C = QW'(QUEUE_DEPTH - 1);
   localparam logic [4:0]    DRAIN_MAX_C = 5'(DRAIN_MAX);

   localparam logic [19:0] BACKOFF_TICKS_RESET = 20'd100000;
   localparam logic [4:0]  DRAIN_LIMIT_RESET = 5'd16;

   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_DRAIN = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic CSR_BACKOFF_TICKS = 1'b0;
   localparam logic CSR_DRAIN_LIMIT = 1'b1;

   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] packet_word;
      logic        reliable_flag;
      logic        host_connected;
      logic [4:0]  sink_credits;
   } req_payload_type;

   typedef struct packed {
      logic        emit_kind;
      logic [31:0] out_packet;
      logic        accepted;
      logic        last_item;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_READ,
      S_EMIT,
      S_DECIDE,
      S_DIRECT,
      S_STATUS
   } state_type;

endpackage

[rtl/rptq_out_buf.sv]
`timescale 1ns / 1ps

module rptq_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  rptq_pkg::rsp_payload_type push_data,
   output logic                     push_ready,
   output logic                     rsp_valid,
   output rptq_pkg::rsp_payload_type rsp_payload,
   input  logic                     rsp_ready
);
   import rptq_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;

   assign push_ready = !valid_ff || rsp_ready;
   assign valid_in = push_valid ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_payload = data_ff;

   a_push_only_when_ready: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready) else $error("item pushed into a full output buffer");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled output item changed");

   a_taken_or_refilled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !push_valid) |=> !rsp_valid)
      else $error("output item repeated");

endmodule

[rtl/reliable_packet_tx_queue.sv]
`timescale 1ns / 1ps

// Ordered transmit queue for 32-bit packets going to a host endpoint.
// Requests arrive on the req_ channel (valid/ready) as one packed item: send a
// packet, service the queue only, or one backoff tick. Results leave on the
// rsp_ channel (valid/ready): drained packets oldest first, a directly sent
// packet, and for a send one status item; the final result of a request has
// last_item set. Registers are to be written through the csr_ port only
// while idle; the block itself does not enforce this. Queued packets live in
// a single-port-read synchronous memory of QUEUE_DEPTH words. One item is
// handled at a time. A tick, an ignored request or a disconnected service
// request ends after its evaluation step, and a disconnected send goes on to
// its status item. Each drained packet takes a memory read step and then an
// emit step. A registered output stage lets a finished result wait while the
// block carries on; when the receiver stalls, the block holds in its next
// output step until the output stage frees up.
// Synchronous reset empties the queue, clears the backoff and restores the
// register defaults; the memory itself is not cleared, as entries are only
// read after they are written.
module reliable_packet_tx_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rptq_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rptq_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [19:0]              csr_wr_data
);
   import rptq_pkg::*;

   state_type       state_ff, state_in;
   req_payload_type item_ff;
   logic [QW-1:0]   head_ff, head_in;
   logic [QW:0]     count_ff, count_in;
   logic [19:0]     backoff_ff, backoff_in;
   logic [4:0]      credits_ff, credits_in;
   logic [4:0]      done_ff, done_in;
   logic            acc_ff, acc_in;
   logic [19:0]     backoff_ticks_ff;
   logic [4:0]      drain_limit_ff;

   logic [31:0]     queue_store_ff [QUEUE_DEPTH];
   logic [31:0]     mem_rd_data_ff;
   logic            mem_rd_en;
   logic            mem_wr_en;
   logic [QW:0]     tail_sum;
   logic [QW-1:0]   tail_idx;
   logic [QW-1:0]   head_next;

   logic [4:0]      limit;
   logic            can_drain;
   logic            more_after;
   logic            queue_full;
   logic            busy;
   logic            push_new;

   logic            ob_push;
   logic            ob_ready;
   rsp_payload_type ob_data;

   assign limit = (drain_limit_ff > DRAIN_MAX_C) ? DRAIN_MAX_C : drain_limit_ff;
   assign can_drain = (count_ff != '0) && (limit != 5'd0) && (credits_ff != 5'd0);
   assign more_after = (count_ff != (QW + 1)'(1)) && ((done_ff + 5'd1) != limit)
                       && (credits_ff != 5'd1);
   assign queue_full = (count_ff == QUEUE_DEPTH_C);
   assign busy = (count_ff != '0) || (backoff_ff != 20'd0);
   assign push_new = item_ff.reliable_flag && !queue_full
                     && (busy || (credits_ff == 5'd0));

   assign tail_sum = {1'b0, head_ff} + count_ff;
   assign tail_idx = (tail_sum >= QUEUE_DEPTH_C) ? QW'(tail_sum - QUEUE_DEPTH_C)
                                                 : tail_sum[QW-1:0];
   assign head_next = (head_ff == QUEUE_LAST_C) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!item_ff.host_connected) begin
               state_in = (item_ff.req_type == REQ_SEND) ? S_STATUS : S_IDLE;
            end else begin
               case (item_ff.req_type)
                  REQ_SEND:  state_in = can_drain ? S_READ : S_DECIDE;
                  REQ_DRAIN: state_in = can_drain ? S_READ : S_IDLE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (ob_ready) begin
               if (more_after) begin
                  state_in = S_READ;
               end else if (item_ff.req_type == REQ_DRAIN) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            state_in = (!busy && (credits_ff != 5'd0)) ? S_DIRECT : S_STATUS;
         end
         S_DIRECT: begin
            if (ob_ready) begin
               state_in = S_STATUS;
            end
         end
         S_STATUS: begin
            if (ob_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mem_rd_en = 1'b0;
      mem_wr_en = 1'b0;
      ob_push = 1'b0;
      ob_data = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_READ: begin
            mem_rd_en = 1'b1;
         end
         S_EMIT: begin
            ob_push = ob_ready;
            ob_data.emit_kind = KIND_PACKET;
            ob_data.out_packet = mem_rd_data_ff;
            ob_data.last_item = (item_ff.req_type == REQ_DRAIN) && !more_after;
         end
         S_DECIDE: begin
            mem_wr_en = push_new;
         end
         S_DIRECT: begin
            ob_push = ob_ready;
            ob_data.emit_kind = KIND_PACKET;
            ob_data.out_packet = item_ff.packet_word;
         end
         S_STATUS: begin
            ob_push = ob_ready;
            ob_data.emit_kind = KIND_STATUS;
            ob_data.accepted = acc_ff;
            ob_data.last_item = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      backoff_in = backoff_ff;
      credits_in = credits_ff;
      done_in = done_ff;
      acc_in = acc_ff;
      case (state_ff)
         S_IDLE: begin
            credits_in = req_payload.sink_credits;
            done_in = 5'd0;
            acc_in = 1'b0;
         end
         S_EVAL: begin
            if (!item_ff.host_connected) begin
               if (item_ff.req_type != REQ_UNUSED) begin
                  head_in = '0;
                  count_in = '0;
                  backoff_in = 20'd0;
               end
            end else if (item_ff.req_type == REQ_TICK && backoff_ff != 20'd0) begin
               backoff_in = backoff_ff - 20'd1;
            end
         end
         S_EMIT: begin
            if (ob_ready) begin
               head_in = head_next;
               count_in = count_ff - 1'b1;
               credits_in = credits_ff - 5'd1;
               done_in = done_ff + 5'd1;
            end
         end
         S_DECIDE: begin
            if (!busy && (credits_ff != 5'd0)) begin
               acc_in = 1'b1;
            end else begin
               acc_in = push_new;
               if (!busy) begin
                  backoff_in = backoff_ticks_ff;
               end
               if (push_new) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         backoff_ff <= 20'd0;
         backoff_ticks_ff <= BACKOFF_TICKS_RESET;
         drain_limit_ff <= DRAIN_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         count_ff <= count_in;
         backoff_ff <= backoff_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BACKOFF_TICKS: backoff_ticks_ff <= csr_wr_data;
               CSR_DRAIN_LIMIT:   drain_limit_ff <= csr_wr_data[4:0];
               default:           drain_limit_ff <= drain_limit_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
      credits_ff <= credits_in;
      done_ff <= done_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         queue_store_ff[tail_idx] <= item_ff.packet_word;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= queue_store_ff[head_ff];
      end
   end

   rptq_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (ob_push),
      .push_data   (ob_data),
      .push_ready  (ob_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_ready   (rsp_ready)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_DEPTH_C) else $error("queue count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= QUEUE_LAST_C) else $error("queue head out of range");

   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_wr_en)) else $error("memory read and write in one cycle");

   a_read_before_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> ($past(state_ff) == S_READ || $past(state_ff) == S_EMIT))
      else $error("packet emitted without a memory read");

   a_drain_needs_entry: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> (count_ff != '0)) else $error("read of an empty queue");

endmodule

[tb/sv/reliable_packet_tx_queue_checker.sv]
`timescale 1ns / 1ps

module reliable_packet_tx_queue_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  rptq_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rptq_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [19:0]               csr_wr_data,
   output int                        fail_count,
   output int                        pending,
   output int                        requests_seen,
   output int                        results_checked,
   output int                        queue_peak
);
   import rptq_pkg::*;

   logic [31:0]     held_packets [QUEUE_DEPTH];
   logic [QW-1:0]   oldest;
   logic [QW:0]     held;
   logic [19:0]     backoff_left;
   logic [19:0]     backoff_reload;
   logic [4:0]      drain_cap;
   rsp_payload_type due_results [$];

   function automatic rsp_payload_type make_result(logic kind, logic [31:0] word, logic acc,
                                                   logic last);
      rsp_payload_type r;
      r.emit_kind = kind;
      r.out_packet = word;
      r.accepted = acc;
      r.last_item = last;
      return r;
   endfunction

   function automatic logic store_packet(logic [31:0] word);
      logic [QW-1:0] slot;
      if (held >= QUEUE_DEPTH_C) begin
         return 1'b0;
      end
      slot = oldest + held[QW-1:0];
      held_packets[slot] = word;
      held = held + 1'b1;
      return 1'b1;
   endfunction

   task automatic drain_held(inout logic [4:0] credits, output int drained);
      logic [4:0] cap;
      cap = (drain_cap > DRAIN_MAX_C) ? DRAIN_MAX_C : drain_cap;
      drained = 0;
      while (held != 0 && drained < int'(cap) && credits != 0) begin
         due_results.push_back(make_result(KIND_PACKET, held_packets[oldest], 1'b0, 1'b0));
         oldest = oldest + 1'b1;
         held = held - 1'b1;
         credits = credits - 1'b1;
         drained++;
      end
   endtask

   task automatic predict_request(input req_payload_type item);
      logic [4:0]      credits;
      int              drained;
      logic            acc;
      rsp_payload_type tail;
      credits = item.sink_credits;
      if (item.req_type == REQ_SEND || item.req_type == REQ_DRAIN
          || item.req_type == REQ_TICK) begin
         requests_seen++;
         if (!item.host_connected) begin
            held = '0;
            oldest = '0;
            backoff_left = '0;
            if (item.req_type == REQ_SEND) begin
               due_results.push_back(make_result(KIND_STATUS, '0, 1'b0, 1'b1));
            end
         end else if (item.req_type == REQ_TICK) begin
            if (backoff_left != 0) begin
               backoff_left = backoff_left - 1'b1;
            end
         end else begin
            drain_held(credits, drained);
            if (item.req_type == REQ_DRAIN) begin
               if (drained > 0) begin
                  tail = due_results.pop_back();
                  tail.last_item = 1'b1;
                  due_results.push_back(tail);
               end
            end else begin
               if (held != 0 || backoff_left != 0) begin
                  acc = item.reliable_flag ? store_packet(item.packet_word) : 1'b0;
               end else if (credits != 0) begin
                  due_results.push_back(make_result(KIND_PACKET, item.packet_word, 1'b0, 1'b0));
                  acc = 1'b1;
               end else begin
                  backoff_left = backoff_reload;
                  acc = item.reliable_flag ? store_packet(item.packet_word) : 1'b0;
               end
               due_results.push_back(make_result(KIND_STATUS, '0, acc, 1'b1));
            end
         end
         if (int'(held) > queue_peak) begin
            queue_peak = int'(held);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         held = '0;
         oldest = '0;
         backoff_left = '0;
         backoff_reload = BACKOFF_TICKS_RESET;
         drain_cap = DRAIN_LIMIT_RESET;
         due_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_BACKOFF_TICKS) begin
               backoff_reload = csr_wr_data;
            end else begin
               drain_cap = csr_wr_data[4:0];
            end
         end
         if (req_valid && req_ready) begin
            predict_request(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result with nothing expected: kind %0d packet %0h accepted %0d last %0d",
                      rsp_payload.emit_kind, rsp_payload.out_packet, rsp_payload.accepted,
                      rsp_payload.last_item);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               results_checked++;
               check_field("emit_kind", 32'(want.emit_kind), 32'(rsp_payload.emit_kind));
               check_field("out_packet", want.out_packet, rsp_payload.out_packet);
               check_field("accepted", 32'(want.accepted), 32'(rsp_payload.accepted));
               check_field("last_item", 32'(want.last_item), 32'(rsp_payload.last_item));
            end
         end
      end
      pending = due_results.size();
   end

endmodule

[tb/sv/reliable_packet_tx_queue_tb.sv]
`timescale 1ns / 1ps

module reliable_packet_tx_queue_tb;
   import rptq_pkg::*;

   localparam int         SETTLE_CYCLES = 40;
   localparam logic [4:0] NO_CREDIT = 5'd0;
   localparam logic [4:0] ALL_CREDIT = 5'd31;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en = 1'b0;
   logic            csr_index = CSR_BACKOFF_TICKS;
   logic [19:0]     csr_wr_data = '0;
   logic            calm = 1'b0;
   int              fail_count;
   int              pending;
   int              requests_seen;
   int              results_checked;
   int              queue_peak;
   int              items_sent = 0;

   reliable_packet_tx_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   reliable_packet_tx_queue_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .requests_seen   (requests_seen),
      .results_checked (results_checked),
      .queue_peak      (queue_peak)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 30);
   end

   function automatic req_payload_type make_request(logic [1:0] kind, logic [31:0] word,
                                                    logic reliable, logic connected,
                                                    logic [4:0] credits);
      req_payload_type item;
      item.req_type = kind;
      item.packet_word = word;
      item.reliable_flag = reliable;
      item.host_connected = connected;
      item.sink_credits = credits;
      return item;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type item;
      int              pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         item.req_type = REQ_SEND;
      end else if (pick < 72) begin
         item.req_type = REQ_DRAIN;
      end else if (pick < 95) begin
         item.req_type = REQ_TICK;
      end else begin
         item.req_type = REQ_UNUSED;
      end
      item.packet_word = $urandom();
      item.reliable_flag = ($urandom_range(99) < 70);
      item.host_connected = ($urandom_range(99) >= 4);
      pick = $urandom_range(99);
      if (pick < 40) begin
         item.sink_credits = NO_CREDIT;
      end else if (pick < 70) begin
         item.sink_credits = 5'($urandom_range(3, 1));
      end else begin
         item.sink_credits = 5'($urandom_range(31));
      end
      return item;
   endfunction

   task automatic send_request(input req_payload_type item);
      if (!calm) begin
         while ($urandom_range(99) < 30) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (item.req_type != REQ_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [19:0] backoff, input logic [19:0] drain);
      settle();
      csr_wr_en = 1'b1;
      csr_index = CSR_BACKOFF_TICKS;
      csr_wr_data = backoff;
      @(negedge clock);
      csr_index = CSR_DRAIN_LIMIT;
      csr_wr_data = drain;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // A backlog is a run of reliable sends with no credit, followed by a send that
   // has credit to spare, so that long drains are exercised.
   task automatic run_random(input int count);
      int stop;
      int pick;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            repeat ($urandom_range(20, 2)) begin
               send_request(make_request(REQ_SEND, $urandom(), 1'b1, 1'b1, NO_CREDIT));
            end
            send_request(make_request(REQ_SEND, $urandom(), 1'($urandom_range(1)), 1'b1,
                                      ALL_CREDIT));
         end else if (pick < 25) begin
            repeat ($urandom_range(8, 2)) begin
               send_request(make_request(REQ_TICK, $urandom(), 1'($urandom_range(1)), 1'b1,
                                         5'($urandom_range(31))));
            end
         end else begin
            send_request(random_request());
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      configure(20'd3, 20'd16);
      send_request(make_request(REQ_SEND, 32'hFFFF_FFFF, 1'b1, 1'b1, ALL_CREDIT));
      send_request(make_request(REQ_SEND, 32'h0000_0000, 1'b0, 1'b1, NO_CREDIT));
      send_request(make_request(REQ_SEND, 32'h1111_1111, 1'b1, 1'b1, 5'd5));
      send_request(make_request(REQ_SEND, 32'h2222_2222, 1'b1, 1'b1, NO_CREDIT));
      send_request(make_request(REQ_SEND, 32'h3333_3333, 1'b0, 1'b1, NO_CREDIT));
      send_request(make_request(REQ_SEND, 32'h4444_4444, 1'b0, 1'b1, 5'd3));
      repeat (4) send_request(make_request(REQ_TICK, 32'h0, 1'b0, 1'b1, NO_CREDIT));
      send_request(make_request(REQ_SEND, 32'h5555_5555, 1'b1, 1'b1, NO_CREDIT));
      send_request(make_request(REQ_DRAIN, 32'h0, 1'b0, 1'b1, NO_CREDIT));
      send_request(make_request(REQ_DRAIN, 32'h0, 1'b0, 1'b1, 5'd1));
      send_request(make_request(REQ_DRAIN, 32'h0, 1'b0, 1'b1, 5'd5));
      send_request(make_request(REQ_UNUSED, 32'hDEAD_BEEF, 1'b1, 1'b0, ALL_CREDIT));
      repeat (3) send_request(make_request(REQ_TICK, 32'h0, 1'b1, 1'b1, ALL_CREDIT));
      send_request(make_request(REQ_SEND, 32'h6666_6666, 1'b1, 1'b1, 5'd1));
      send_request(make_request(REQ_SEND, 32'h7777_7777, 1'b1, 1'b1, NO_CREDIT));
      send_request(make_request(REQ_TICK, 32'h0, 1'b0, 1'b0, ALL_CREDIT));
      send_request(make_request(REQ_DRAIN, 32'h0, 1'b0, 1'b0, ALL_CREDIT));
      send_request(make_request(REQ_SEND, 32'h8888_8888, 1'b1, 1'b0, ALL_CREDIT));
      send_request(make_request(REQ_SEND, 32'h5A5A_A5A5, 1'b0, 1'b1, ALL_CREDIT));

      configure(20'd0, 20'd1);
      run_random(45);

      // Sends are offered past the queue's depth, then the queue is emptied by full-length drains.
      configure(20'hFFFFF, 20'd31);
      send_request(make_request(REQ_SEND, $urandom(), 1'b1, 1'b1, NO_CREDIT));
      repeat (QUEUE_DEPTH + 2) begin
         send_request(make_request(REQ_SEND, $urandom(), 1'b1, 1'b1, NO_CREDIT));
      end
      repeat (QUEUE_DEPTH / DRAIN_MAX + 1) begin
         send_request(make_request(REQ_DRAIN, $urandom(), 1'b0, 1'b1, ALL_CREDIT));
      end
      run_random(15);

      configure(20'd6, 20'd0);
      run_random(40);

      calm = 1'b1;
      configure(20'd3, 20'd16);
      run_random(45);
      calm = 1'b0;

      configure(20'($urandom_range(20, 1)), 20'($urandom_range(16, 1)));
      run_random(40);

      settle();
      $display("Run covered %0d requests and %0d checked results over six register settings;",
               requests_seen, results_checked);
      $display("the queue held at most %0d packets.", queue_peak);
      if (fail_count == 0 && pending == 0) begin
         $display("reliable_packet_tx_queue_tb: clean");
      end else begin
         $display("reliable_packet_tx_queue_tb: errors");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Run stopped: no progress within the time limit.");
      $display("reliable_packet_tx_queue_tb: errors");
      $finish;
   end

endmodule
